// ===== hw/rtl/orb_pkg.sv =====
package orb_pkg;

   // Storage geometry.
   localparam int DEPTH        = 64;
   localparam int RECORD_WIDTH = 64;
   localparam int ADDR_W       = $clog2(DEPTH);

   // Fixed field widths of the item ports.
   localparam int REC_FIELD_W = 64;
   localparam int POS_W       = 6;
   localparam int HELD_W      = 7;
   localparam int CAP_W       = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // Operation codes.
   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_DUMP  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   // Input item.
   typedef struct packed {
      func_type                func;
      logic [REC_FIELD_W-1:0]  record_in;
      logic [POS_W-1:0]        read_index;
   } req_type;

   // Result item.
   typedef struct packed {
      status_type              status;
      logic [REC_FIELD_W-1:0]  record_out;
      logic [POS_W-1:0]        position;
      logic [HELD_W-1:0]       held_count;
      logic                    last;
   } rsp_type;

   // Memory access from the controller, one write and one read port.
   typedef struct packed {
      logic                     we;
      logic [ADDR_W-1:0]        waddr;
      logic [RECORD_WIDTH-1:0]  wdata;
      logic [ADDR_W-1:0]        raddr;
   } mem_cmd_type;

   // Result fields that travel alongside the memory read.
   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [POS_W-1:0]  position;
      logic [HELD_W-1:0] held_count;
      logic              last;
      logic              use_mem;
   } meta_type;

endpackage

// ===== hw/rtl/orb_ram.sv =====
module orb_ram
   import orb_pkg::*;
(
   input  logic                    clock,
   input  mem_cmd_type             cmd,
   output logic [RECORD_WIDTH-1:0] rd_data
);

   logic [RECORD_WIDTH-1:0] mem [DEPTH];
   logic [RECORD_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[cmd.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/orb_ctrl.sv =====
module orb_ctrl
   import orb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data,
   output mem_cmd_type      cmd,
   output meta_type         meta
);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic               full_ff, full_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [POS_W-1:0]   dcnt_ff, dcnt_in;
   meta_type           meta_ff, meta_in;

   logic [HELD_W-1:0]  cap_eff;
   logic [HELD_W-1:0]  held;
   logic [HELD_W-1:0]  wp_ext;
   logic [HELD_W-1:0]  wp_eff;
   logic [HELD_W-1:0]  wp_next;
   logic [HELD_W-1:0]  held_push;
   logic [POS_W-1:0]   rd_pos;
   logic [HELD_W-1:0]  slot_sum;
   logic [HELD_W-1:0]  slot;
   logic               dump_last;

   // Effective capacity: zero acts as one, anything above the depth as the depth.
   always_comb begin
      priority if (cap_ff == '0) begin
         cap_eff = HELD_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         cap_eff = HELD_W'(DEPTH);
      end else begin
         cap_eff = HELD_W'(cap_ff);
      end
   end

   assign wp_ext = HELD_W'(wp_ff);
   assign held   = full_ff ? cap_eff : wp_ext;

   // Push pointer arithmetic.
   assign wp_eff    = (wp_ext >= cap_eff) ? '0 : wp_ext;
   assign wp_next   = wp_eff + HELD_W'(1);
   assign held_push = (full_ff || (wp_next >= cap_eff)) ? cap_eff : wp_next;

   // Slot of a position counted from the oldest entry; the sum stays below
   // twice the capacity, so one subtract does the wrap.
   always_comb begin
      if (state_ff == ST_DUMP) begin
         rd_pos = dcnt_ff;
      end else if (req_item.func == FUNC_DUMP) begin
         rd_pos = '0;
      end else begin
         rd_pos = req_item.read_index;
      end
   end

   assign slot_sum  = (full_ff ? wp_ext : '0) + HELD_W'(rd_pos);
   assign slot      = (slot_sum >= cap_eff) ? (slot_sum - cap_eff) : slot_sum;
   assign dump_last = ((HELD_W'(dcnt_ff) + HELD_W'(1)) == held);

   assign busy      = (state_ff == ST_DUMP);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   // Next state, memory commands and result fields.
   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      full_in   = full_ff;
      cap_in    = cap_ff;
      dcnt_in   = dcnt_ff;
      meta_in   = '0;
      cmd       = '0;
      cmd.raddr = ADDR_W'(slot);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               meta_in.valid = 1'b1;
               meta_in.last  = 1'b1;
               unique case (req_item.func)
                  FUNC_PUSH: begin
                     cmd.we    = 1'b1;
                     cmd.waddr = ADDR_W'(wp_eff);
                     cmd.wdata = req_item.record_in[RECORD_WIDTH-1:0];
                     if (wp_next >= cap_eff) begin
                        wp_in   = '0;
                        full_in = 1'b1;
                     end else begin
                        wp_in = ADDR_W'(wp_next);
                     end
                     meta_in.status     = STAT_OK;
                     meta_in.position   = POS_W'(held_push - HELD_W'(1));
                     meta_in.held_count = held_push;
                  end
                  FUNC_READ: begin
                     meta_in.position   = req_item.read_index;
                     meta_in.held_count = held;
                     if (HELD_W'(req_item.read_index) >= held) begin
                        meta_in.status = STAT_RANGE;
                     end else begin
                        meta_in.status  = STAT_OK;
                        meta_in.use_mem = 1'b1;
                     end
                  end
                  FUNC_DUMP: begin
                     if (held == '0) begin
                        meta_in.status = STAT_EMPTY;
                     end else begin
                        meta_in.status     = STAT_OK;
                        meta_in.use_mem    = 1'b1;
                        meta_in.held_count = held;
                        if (held != HELD_W'(1)) begin
                           meta_in.last = 1'b0;
                           state_in     = ST_DUMP;
                           dcnt_in      = POS_W'(1);
                        end
                     end
                  end
                  FUNC_CLEAR: begin
                     wp_in          = '0;
                     full_in        = 1'b0;
                     meta_in.status = STAT_OK;
                  end
               endcase
            end else if (csr_valid) begin
               cap_in  = csr_data;
               wp_in   = '0;
               full_in = 1'b0;
            end
         end
         ST_DUMP: begin
            meta_in.valid      = 1'b1;
            meta_in.status     = STAT_OK;
            meta_in.use_mem    = 1'b1;
            meta_in.position   = dcnt_ff;
            meta_in.held_count = held;
            meta_in.last       = dump_last;
            if (dump_last) begin
               state_in = ST_IDLE;
            end else begin
               dcnt_in = dcnt_ff + POS_W'(1);
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wp_ff    <= '0;
         full_ff  <= 1'b0;
         cap_ff   <= CAP_RESET;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         full_ff  <= full_in;
         cap_ff   <= cap_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   // Result fields, aligned with the memory read data; only the strobe is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff.valid <= 1'b0;
      end else begin
         meta_ff.valid <= meta_in.valid;
      end
      meta_ff.status     <= meta_in.status;
      meta_ff.position   <= meta_in.position;
      meta_ff.held_count <= meta_in.held_count;
      meta_ff.last       <= meta_in.last;
      meta_ff.use_mem    <= meta_in.use_mem;
   end

   assign meta = meta_ff;

endmodule

// ===== hw/rtl/overwrite_ring_buffer_core.sv =====
// Channel   Ports                                  Transfer
// -------   ------------------------------------   ---------------------------------
// request   start, busy, req_item                  start high while busy is low
// result    rsp_valid, rsp_item                    rsp_valid high, one cycle, no stall
// config    csr_valid, csr_ready, csr_data         csr_valid and csr_ready both high
//
// Push, read and clear may follow back to back; each result passes through the
// synchronous memory read, with its fields registered alongside, then the output
// register. A dump of more than one entry holds busy until the read of its last
// entry, one memory read per entry. Reset is synchronous; the record memory is not
// cleared and needs no clearing pass. The result side cannot stall.
module overwrite_ring_buffer_core
   import orb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);

   mem_cmd_type             cmd;
   meta_type                meta;
   logic [RECORD_WIDTH-1:0] rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   orb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .meta      (meta)
   );

   orb_ram u_ram (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   // Merge the read data into the result item.
   always_comb begin
      rsp_valid_in           = meta.valid;
      rsp_item_in.status     = meta.status;
      rsp_item_in.record_out = meta.use_mem ? REC_FIELD_W'(rd_data) : '0;
      rsp_item_in.position   = meta.position;
      rsp_item_in.held_count = meta.held_count;
      rsp_item_in.last       = meta.last;
   end

   // Output register: strobe is control state, the item is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== sim/overwrite_ring_buffer_core_tb.sv =====
module overwrite_ring_buffer_core_tb
   import orb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 100000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   req_type          req_item  = '0;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data  = '0;

   // Local copy of the ring state and the capacity register.
   logic [RECORD_WIDTH-1:0] ring_store [DEPTH];
   int                      ring_wp;
   bit                      ring_full;
   logic [CAP_W-1:0]        cap_reg;

   rsp_type pending_rsp [$];

   int fail_count      = 0;
   int items_sent      = 0;
   int dumps_sent      = 0;
   int results_checked = 0;
   int settings_used   = 0;
   int cycle_count     = 0;
   bit no_idle         = 1'b0;

   overwrite_ring_buffer_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run guard against a hung handshake or missing results.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("overwrite_ring_buffer_core verification failed");
         $finish;
      end
   end

   // Register values of 0 and above DEPTH are clamped into range.
   function automatic int effective_capacity();
      int c;
      c = int'(cap_reg);
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic int held_entries();
      return ring_full ? effective_capacity() : ring_wp;
   endfunction

   function automatic void clear_ring();
      for (int i = 0; i < DEPTH; i++) ring_store[i] = '0;
      ring_wp   = 0;
      ring_full = 1'b0;
   endfunction

   // Position zero is the oldest entry; once full, that sits at the write pointer.
   function automatic logic [REC_FIELD_W-1:0] entry_at(int pos);
      int c;
      int first;
      c     = effective_capacity();
      first = ring_full ? ring_wp : 0;
      return REC_FIELD_W'(ring_store[(first + pos) % c]);
   endfunction

   function automatic rsp_type make_rsp(status_type st, logic [REC_FIELD_W-1:0] rec,
                                        int pos, int cnt, bit lst);
      rsp_type r;
      r.status     = st;
      r.record_out = rec;
      r.position   = POS_W'(pos);
      r.held_count = HELD_W'(cnt);
      r.last       = lst;
      return r;
   endfunction

   // Append one expected result behind those already waiting.
   function automatic void add_expected(rsp_type r);
      pending_rsp = {pending_rsp, r};
   endfunction

   // Work out the results of one accepted item and queue them.
   function automatic void predict_ring_results(req_type it);
      int c;
      int n;
      int idx;
      c   = effective_capacity();
      idx = int'(it.read_index);
      case (it.func)
         FUNC_PUSH: begin
            if (ring_wp >= c) ring_wp = 0;
            ring_store[ring_wp] = it.record_in[RECORD_WIDTH-1:0];
            ring_wp++;
            if (ring_wp >= c) begin
               ring_wp   = 0;
               ring_full = 1'b1;
            end
            n = held_entries();
            add_expected(make_rsp(STAT_OK, '0, n - 1, n, 1'b1));
         end
         FUNC_READ: begin
            n = held_entries();
            if (idx >= n) begin
               add_expected(make_rsp(STAT_RANGE, '0, idx, n, 1'b1));
            end else begin
               add_expected(make_rsp(STAT_OK, entry_at(idx), idx, n, 1'b1));
            end
         end
         FUNC_DUMP: begin
            n = held_entries();
            if (n == 0) begin
               add_expected(make_rsp(STAT_EMPTY, '0, 0, 0, 1'b1));
            end else begin
               for (int i = 0; i < n; i++) begin
                  add_expected(make_rsp(STAT_OK, entry_at(i), i, n, i + 1 == n));
               end
            end
         end
         default: begin
            clear_ring();
            add_expected(make_rsp(STAT_OK, '0, 0, 0, 1'b1));
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Each result strobe is compared with the oldest expected result.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("result item with none expected: %p", rsp_item);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            check_field("status", 64'(exp_rsp.status), 64'(rsp_item.status));
            check_field("record_out", exp_rsp.record_out, rsp_item.record_out);
            check_field("position", 64'(exp_rsp.position), 64'(rsp_item.position));
            check_field("held_count", 64'(exp_rsp.held_count), 64'(rsp_item.held_count));
            check_field("last", 64'(exp_rsp.last), 64'(rsp_item.last));
            results_checked++;
         end
      end
   end

   function automatic req_type make_req(func_type f, logic [REC_FIELD_W-1:0] rec,
                                        logic [POS_W-1:0] idx);
      req_type it;
      it.func       = f;
      it.record_in  = rec;
      it.read_index = idx;
      return it;
   endfunction

   // Start stays high after acceptance so that a back-to-back item needs no
   // second assignment in the same step; it is lowered before a gap and when draining.
   task automatic send_item(input req_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      predict_ring_results(it);
      items_sent++;
      if (it.func == FUNC_DUMP) dumps_sent++;
   endtask

   // Lower start and wait until every expected result has come.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cap_reg = value;
      clear_ring();
      settings_used++;
   endtask

   // Mostly pushes and in-range reads so the ring fills and wraps.
   function automatic req_type random_item();
      req_type it;
      int      r;
      int      n;
      r = $urandom_range(0, 99);
      n = held_entries();
      it.record_in  = {$urandom(), $urandom()};
      it.read_index = POS_W'($urandom_range(0, 63));
      if (r < 50) begin
         it.func = FUNC_PUSH;
      end else if (r < 78) begin
         it.func = FUNC_READ;
         if (n > 0 && $urandom_range(0, 3) != 0) it.read_index = POS_W'($urandom_range(0, n - 1));
      end else if (r < 93) begin
         it.func = FUNC_DUMP;
      end else begin
         it.func = FUNC_CLEAR;
      end
      return it;
   endfunction

   // Reads, dumps and clears on a buffer that holds nothing.
   task automatic test_empty_buffer();
      send_item(make_req(FUNC_READ, '0, 6'd0));
      send_item(make_req(FUNC_READ, '1, 6'd63));
      send_item(make_req(FUNC_DUMP, '0, 6'd0));
      send_item(make_req(FUNC_CLEAR, '1, 6'd63));
   endtask

   // Extreme record words, reads in and out of range, dump, then clear and dump again.
   task automatic test_push_read_extremes();
      send_item(make_req(FUNC_PUSH, 64'h0, 6'd63));
      send_item(make_req(FUNC_PUSH, '1, 6'd0));
      send_item(make_req(FUNC_PUSH, 64'hA5A5_5A5A_0F0F_F0F0, 6'd21));
      send_item(make_req(FUNC_READ, '0, 6'd0));
      send_item(make_req(FUNC_READ, '0, 6'd2));
      send_item(make_req(FUNC_READ, '1, 6'd3));
      send_item(make_req(FUNC_READ, '0, 6'd63));
      send_item(make_req(FUNC_DUMP, '1, 6'd42));
      send_item(make_req(FUNC_CLEAR, '0, 6'd0));
      send_item(make_req(FUNC_DUMP, '0, 6'd0));
   endtask

   // At capacity 2 the third push overwrites the oldest entry.
   task automatic test_wrap_overwrite();
      write_capacity(7'd2);
      send_item(make_req(FUNC_PUSH, 64'h1111_1111_1111_1111, 6'd0));
      send_item(make_req(FUNC_PUSH, 64'h2222_2222_2222_2222, 6'd0));
      send_item(make_req(FUNC_PUSH, 64'h3333_3333_3333_3333, 6'd0));
      send_item(make_req(FUNC_READ, '0, 6'd0));
      send_item(make_req(FUNC_READ, '0, 6'd1));
      send_item(make_req(FUNC_READ, '0, 6'd2));
      send_item(make_req(FUNC_DUMP, '0, 6'd0));
   endtask

   // Register value zero acts as one and values above DEPTH act as DEPTH;
   // the write itself must leave the buffer empty.
   task automatic test_capacity_clamp();
      write_capacity(7'd0);
      send_item(make_req(FUNC_DUMP, '0, 6'd0));
      send_item(make_req(FUNC_PUSH, 64'hDEAD_BEEF_0000_0001, 6'd0));
      send_item(make_req(FUNC_PUSH, 64'hDEAD_BEEF_0000_0002, 6'd0));
      send_item(make_req(FUNC_READ, '0, 6'd0));
      write_capacity(7'd127);
      send_item(make_req(FUNC_PUSH, 64'h8000_0000_0000_0001, 6'd0));
      send_item(make_req(FUNC_READ, '0, 6'd1));
   endtask

   // Fill all 64 entries with wrap, then read the ends and dump everything.
   task automatic test_full_depth();
      write_capacity(7'd64);
      no_idle = 1'b0;
      for (int i = 0; i < 66; i++) begin
         if (i == 20) no_idle = 1'b1;
         if (i == 40) no_idle = 1'b0;
         send_item(make_req(FUNC_PUSH, {$urandom(), $urandom()}, POS_W'($urandom_range(0, 63))));
      end
      send_item(make_req(FUNC_READ, '0, 6'd0));
      send_item(make_req(FUNC_READ, '0, 6'd63));
      send_item(make_req(FUNC_DUMP, '0, 6'd0));
   endtask

   // Random operation mix over a range of capacity settings.
   task automatic test_random_mix();
      logic [CAP_W-1:0] caps [6];
      caps[0] = 7'd1;
      caps[1] = 7'd3;
      caps[2] = 7'd5;
      caps[3] = 7'd100;
      caps[4] = 7'd64;
      caps[5] = CAP_W'($urandom_range(1, 64));
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         no_idle = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < 5; i++) send_item(random_item());
      end
   endtask

   initial begin
      cap_reg = CAP_RESET;
      clear_ring();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_buffer();
      test_push_read_extremes();
      test_wrap_overwrite();
      test_capacity_clamp();
      test_full_depth();
      test_random_mix();

      drain_results();
      repeat (8) @(posedge clock);

      $display("Summary: %0d items sent (%0d dumps), %0d results checked,", items_sent,
               dumps_sent, results_checked);
      $display("Summary: %0d capacity settings written, %0d mismatches.", settings_used,
               fail_count);
      if (fail_count == 0) begin
         $display("overwrite_ring_buffer_core verification clean");
      end else begin
         $display("overwrite_ring_buffer_core verification failed");
      end
      $finish;
   end

endmodule

// ===== overwrite_ring_buffer_core.f =====
hw/rtl/orb_pkg.sv
hw/rtl/orb_ram.sv
hw/rtl/orb_ctrl.sv
hw/rtl/overwrite_ring_buffer_core.sv
sim/overwrite_ring_buffer_core_tb.sv
